FILE: rtl/cyclic_prefix_threshold_search_core_assert.svh
// Assertion macros for the cyclic prefix threshold search core.
// Depends on nothing; included by the top level.
`ifndef CYCLIC_PREFIX_THRESHOLD_SEARCH_CORE_ASSERT_SVH
`define CYCLIC_PREFIX_THRESHOLD_SEARCH_CORE_ASSERT_SVH
// same-cycle implication
`define CPTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cpts assertion failed");
// next-cycle implication
`define CPTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cpts assertion failed");
`endif

FILE: rtl/cpts_pkg.sv
// Shared types and constants for the cyclic prefix threshold search core.
// No dependencies.
package cpts_pkg;
    localparam int SUM_W = 42;
    localparam int DIV_W = 43;
    localparam int DIV_CNT_W = 6;

    localparam logic [1:0] REQ_RESTART = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_QUERY   = 2'd2;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [DIV_W-1:0] div_word_t;
endpackage

FILE: rtl/cyclic_prefix_threshold_search_core.sv
// Cyclic prefix threshold search core, top level.
// Depends on cpts_pkg, cpts_div and cyclic_prefix_threshold_search_core_assert.svh.
//
// Input channel s_*: s_tuser carries the request (restart, append, query),
// s_tdata the element and the threshold. Restart and append give no
// result. A query gives one result on m_*: the answer step in
// m_tdata and the not-reached flag in m_tuser.
// Query steps: when the threshold lies within the stored maximum, a binary
// search over the prefix maximum memory; otherwise a shift-subtract divider,
// then a shift-add of the cycle count by n, then the binary search for the
// remainder.
// s_tready is low while a query runs; one item is processed at a time.
// A finished result sits in the output register; appends and restarts are
// still taken while it waits, and a further query holds its result until
// m_tready frees the register.
// Reset (synchronous, aresetn low) empties the sequence and drops any
// pending result. The prefix maximum memory is not cleared: only entries
// below the element count are ever read.
module cyclic_prefix_threshold_search_core
    import cpts_pkg::*;
#(
    parameter int MAX_LEN   = 1024,
    parameter int ELEM_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // element_value[31:0], threshold[62:32]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // answer_step[41:0]
    output logic [0:0]  m_tuser   // not_reached[0]
);
    `include "cyclic_prefix_threshold_search_core_assert.svh"

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_CMP  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    sum_t             total_reg, total_next;
    sum_t             max_reg, max_next;
    sum_t             target_reg, target_next;
    logic [SUM_W-1:0] base_reg, base_next;
    logic [SUM_W-1:0] mcand_reg, mcand_next;
    logic [CW-1:0]    mplier_reg, mplier_next;
    logic [IW-1:0]    lo_reg, lo_next;
    logic [IW-1:0]    hi_reg, hi_next;
    logic [SUM_W-1:0] ans_reg, ans_next;
    logic             nr_reg, nr_next;
    logic             mv_reg, mv_next;
    logic [SUM_W-1:0] mdata_reg, mdata_next;
    logic             muser_reg, muser_next;
    sum_t             rd_data_reg;
    sum_t             mem [MAX_LEN];

    logic             accept;
    logic [1:0]       req;
    sum_t             elem;
    sum_t             thr;
    sum_t             new_total;
    logic             do_append;
    logic             div_start;
    div_word_t        div_dividend;
    div_word_t        div_divisor;
    logic             div_done;
    div_word_t        div_quo;
    div_word_t        div_rem;
    logic [SUM_W+1:0] dividend_w;
    logic [SUM_W+1:0] target_w;
    logic [IW:0]      mid_w;
    logic [IW-1:0]    mid;
    logic             out_free;

    assign accept    = s_tvalid && s_tready;
    assign req       = s_tuser;
    assign elem      = SUM_W'($signed(s_tdata[ELEM_BITS-1:0]));
    assign thr       = SUM_W'(s_tdata[62:32]);
    assign new_total = total_reg + elem;
    assign do_append = accept && (req == REQ_APPEND) && (count_reg < CW'(MAX_LEN));
    assign out_free  = !mv_reg || m_tready;

    assign dividend_w = SUM_W'(0) + {{2{thr[SUM_W-1]}}, thr} - {{2{max_reg[SUM_W-1]}}, max_reg}
                      + {{2{total_reg[SUM_W-1]}}, total_reg} - (SUM_W+2)'(1);
    assign div_dividend = dividend_w[DIV_W-1:0];
    assign div_divisor  = {1'b0, total_reg};

    assign target_w = {{2{max_reg[SUM_W-1]}}, max_reg} - {{2{total_reg[SUM_W-1]}}, total_reg}
                    + (SUM_W+2)'(1) + {1'b0, div_rem};

    assign mid_w = ({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1;
    assign mid   = mid_w[IW-1:0];

    cpts_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        max_next    = max_reg;
        target_next = target_reg;
        base_next   = base_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ans_next    = ans_reg;
        nr_next     = nr_reg;
        mv_next     = mv_reg && !m_tready;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        div_start   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_RESTART: begin
                            count_next = '0;
                            total_next = '0;
                            max_next   = '0;
                        end
                        REQ_APPEND: begin
                            if (do_append) begin
                                total_next = new_total;
                                if (count_reg == '0 || new_total > max_reg) begin
                                    max_next = new_total;
                                end
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            lo_next    = '0;
                            hi_next    = IW'(count_reg - 1'b1);
                            base_next  = '0;
                            target_next = thr;
                            ans_next   = '0;
                            nr_next    = 1'b1;
                            if (count_reg == '0) begin
                                state_next = ST_DONE;
                            end else if (thr <= max_reg) begin
                                state_next = ST_RD;
                            end else if (total_reg <= 0) begin
                                state_next = ST_DONE;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mcand_next  = div_quo[SUM_W-1:0];
                    mplier_next = count_reg;
                    base_next   = '0;
                    target_next = target_w[SUM_W-1:0];
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg == '0) begin
                    state_next = ST_RD;
                end else begin
                    if (mplier_reg[0]) begin
                        base_next = base_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end
            ST_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_CMP;
                end else begin
                    ans_next   = base_reg + SUM_W'(lo_reg);
                    nr_next    = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                if (rd_data_reg >= target_reg) begin
                    hi_next = mid;
                end else begin
                    lo_next = mid + 1'b1;
                end
                state_next = ST_RD;
            end
            ST_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mdata_next = ans_reg;
                    muser_next = nr_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            max_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            max_reg   <= max_next;
            mv_reg    <= mv_next;
        end
        target_reg <= target_next;
        base_reg   <= base_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ans_reg    <= ans_next;
        nr_reg     <= nr_next;
        mdata_reg  <= mdata_next;
        muser_reg  <= muser_next;
    end

    always_ff @(posedge aclk) begin
        if (do_append) begin
            mem[count_reg[IW-1:0]] <= (count_reg == '0 || new_total > max_reg) ?
                                      new_total : max_reg;
        end
        rd_data_reg <= mem[mid];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'b0, mdata_reg};
    assign m_tuser  = muser_reg;

    `CPTS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(MAX_LEN))
    `CPTS_ASSERT_IMPL(a_search_order, state_reg == ST_CMP, lo_reg < hi_reg)
    `CPTS_ASSERT_IMPL(a_nr_zero, m_tvalid && m_tuser[0], m_tdata[41:0] == '0)
    `CPTS_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser == REQ_QUERY, !s_tready)
endmodule

FILE: rtl/cpts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cpts_pkg.
module cpts_div
    import cpts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  div_word_t dividend,
    input  div_word_t divisor,
    output logic      done,
    output div_word_t quotient,
    output div_word_t remainder
);
    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    div_word_t            rem_reg, rem_next;
    div_word_t            quo_reg, quo_next;
    div_word_t            dsr_reg, dsr_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

FILE: dv/tb.sv
// Testbench for cyclic_prefix_threshold_search_core: restart, append and query traffic
// with a built-in answer predictor and an in-order result check.
// Depends on cpts_pkg and the core RTL.
module tb;
    import cpts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_MAX = 1024;
    localparam longint CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = REQ_RESTART;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    typedef struct packed {
        logic [41:0] step;
        logic        miss;
    } answer_t;

    answer_t answer_q[$];
    int      err_cnt = 0;
    longint  cyc = 0;
    int      send_idle = 0;
    int      recv_idle = 0;

    int          seq_len = 0;
    sum_t        seq_sum = '0;
    sum_t        seq_peak = '0;
    sum_t        peak_mem[N_MAX];

    cyclic_prefix_threshold_search_core uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int first_index(sum_t t);
        int lo, hi, mid;
        lo = 0;
        hi = seq_len - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (peak_mem[mid] >= t) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    task automatic predict_request(logic [1:0] req, logic [31:0] elem, logic [30:0] thr);
        answer_t a;
        sum_t t, k, r;
        if (req == REQ_RESTART) begin
            seq_len = 0;
            seq_sum = '0;
            seq_peak = '0;
        end else if (req == REQ_APPEND) begin
            if (seq_len < N_MAX) begin
                seq_sum = seq_sum + sum_t'(signed'(elem));
                if (seq_len == 0 || seq_sum > seq_peak) seq_peak = seq_sum;
                peak_mem[seq_len] = seq_peak;
                seq_len++;
            end
        end else if (req == REQ_QUERY) begin
            a.step = '0;
            a.miss = 1'b1;
            t = sum_t'({1'b0, thr});
            if (seq_len != 0) begin
                if (t <= seq_peak) begin
                    a.step = 42'(first_index(t));
                    a.miss = 1'b0;
                end else if (seq_sum > 0) begin
                    k = (t - seq_peak + seq_sum - 1) / seq_sum;
                    r = t - k * seq_sum;
                    a.step = 42'(k * seq_len + first_index(r));
                    a.miss = 1'b0;
                end
            end
            answer_q = {answer_q, a};
        end
    endtask

    task automatic send_item(logic [1:0] req, logic [31:0] elem, logic [30:0] thr);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {1'b0, thr, elem};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(req, elem, thr);
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle);

    always @(posedge aclk) begin
        answer_t exp_a;
        if (aresetn && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result step=%0d miss=%0d", m_tdata[41:0], m_tuser[0]);
                err_cnt++;
            end else begin
                exp_a = answer_q.pop_front();
                if (m_tdata[41:0] !== exp_a.step) begin
                    $error("answer_step expected %0d got %0d", exp_a.step, m_tdata[41:0]);
                    err_cnt++;
                end
                if (m_tuser[0] !== exp_a.miss) begin
                    $error("not_reached expected %0d got %0d", exp_a.miss, m_tuser[0]);
                    err_cnt++;
                end
            end
        end
    end

    function automatic logic [30:0] rand_thr();
        case ($urandom_range(3))
            0: return 31'($urandom_range(1, 64));
            1: return 31'($urandom_range(1, 5000));
            2: return 31'($urandom);
            default: return 31'($urandom_range(1, 1 << 20));
        endcase
    endfunction

    function automatic logic [31:0] rand_elem(int bias);
        case ($urandom_range(4))
            0: return 32'($urandom);
            1: return 32'($urandom_range(0, 200)) - 32'(bias);
            2: return 32'($urandom_range(0, 1 << 16)) - 32'(bias << 8);
            default: return 32'($urandom_range(0, 40)) - 32'(bias);
        endcase
    endfunction

    task automatic test_empty_and_unused();
        send_item(REQ_QUERY, '0, 31'd1);
        send_item(REQ_QUERY, '0, 31'h7fffffff);
        send_item(2'd3, 32'hffffffff, 31'h7fffffff);
        send_item(REQ_APPEND, 32'd5, '0);
        send_item(REQ_RESTART, 32'hffffffff, 31'h7fffffff);
        send_item(REQ_QUERY, 32'hffffffff, 31'd5);
    endtask

    task automatic test_extremes();
        send_item(REQ_APPEND, 32'h7fffffff, '0);
        send_item(REQ_APPEND, 32'h80000000, '0);
        send_item(REQ_QUERY, '0, 31'h7fffffff);
        send_item(REQ_QUERY, '0, 31'd1);
        send_item(REQ_APPEND, 32'h80000000, '0);
        send_item(REQ_QUERY, '0, 31'h7fffffff);
        send_item(REQ_RESTART, '0, '0);
        send_item(REQ_APPEND, 32'd3, '0);
        send_item(REQ_APPEND, 32'hfffffffe, '0);
        send_item(REQ_QUERY, '0, 31'd3);
        send_item(REQ_QUERY, '0, 31'h7fffffff);
        send_item(REQ_QUERY, '0, 31'd1000);
        send_item(REQ_RESTART, '0, '0);
        send_item(REQ_APPEND, 32'hfffffffb, '0);
        send_item(REQ_QUERY, '0, 31'd1);
        send_item(REQ_QUERY, '0, 31'd0);
    endtask

    task automatic test_full_sequence();
        send_item(REQ_RESTART, '0, '0);
        for (int i = 0; i < N_MAX + 4; i++)
            send_item(REQ_APPEND, (i % 3 == 0) ? 32'hfffffffe : 32'd1, '0);
        send_item(REQ_QUERY, '0, 31'd1);
        send_item(REQ_QUERY, '0, 31'h7fffffff);
        send_item(REQ_QUERY, '0, rand_thr());
    endtask

    task automatic test_random(int n_items);
        int sent, len, bias;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_item(2'($urandom), 32'($urandom), 31'($urandom));
                sent++;
                continue;
            end
            send_item(REQ_RESTART, 32'($urandom), 31'($urandom));
            len = ($urandom_range(19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
            bias = $urandom_range(0, 120);
            for (int i = 0; i < len; i++) begin
                send_item(REQ_APPEND, rand_elem(bias), 31'($urandom));
                sent++;
            end
            repeat ($urandom_range(1, 6)) begin
                send_item(REQ_QUERY, 32'($urandom), rand_thr());
                sent++;
            end
        end
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(posedge aclk);
        while (n < 100) begin
            @(posedge aclk);
            n++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 38;
        recv_idle = 79;
        test_empty_and_unused();
        test_extremes();
        test_random(250);
        send_idle = 79;
        recv_idle = 38;
        test_full_sequence();
        test_random(250);
        send_idle = 0;
        recv_idle = 0;
        test_random(260);
        drain();
        if (err_cnt == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
